@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication that must hold at every clock edge outside reset.
`define SPT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define SPT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPT_ASSERT(label, clk, rst_n, prop, msg)
`define SPT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/spt_pkg.sv @@
package spt_pkg;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_UDP  = 2'd1,
    KIND_TCP  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_BIND   = 3'd1,
    CMD_CLOSE  = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_AUTO   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DONE,
    S_TRY
  } state_e;

  localparam int unsigned EphTries = 16384;
  localparam int unsigned TryW     = $clog2(EphTries);
  localparam logic [15:0] EphReset = 16'd49152;

  // Per-cell compare results, shifted toward cell 0 during a scan
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic        exact;
    logic        wild;
    logic        conf_u;
    logic        conf_t;
  } cell_flags_t;

  // Broadcast request to all cells
  typedef struct packed {
    logic        load;
    logic        shift;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] cand;
  } cell_req_t;

  // Entry write, with per-field enables
  typedef struct packed {
    logic        en;
    logic        wr_kind;
    logic        wr_ip;
    logic        wr_port;
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [15:0] port;
  } cell_wr_t;

endpackage

@@ rtl/core/spt_cmd_if.sv @@
interface spt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic        sock_kind;
  logic [3:0]  sock_index;
  logic [31:0] ip_addr;
  logic [15:0] port_num;

  modport source (output valid, cmd, sock_kind, sock_index, ip_addr, port_num, input ready);
  modport sink (input valid, cmd, sock_kind, sock_index, ip_addr, port_num, output ready);
endinterface

@@ rtl/core/spt_rsp_if.sv @@
interface spt_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  result_index;
  logic [15:0] result_port;

  modport source (output valid, status, result_index, result_port, input ready);
  modport sink (input valid, status, result_index, result_port, output ready);
endinterface

@@ rtl/core/spt_cfg_if.sv @@
interface spt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ephemeral_base;

  modport source (output valid, ephemeral_base, input ready);
  modport sink (input valid, ephemeral_base, output ready);
endinterface

@@ rtl/core/spt_cell.sv @@
module spt_cell #(
  parameter int unsigned IDX_W   = 4,
  parameter int unsigned CELL_ID = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spt_pkg::cell_req_t       req_i,
  input  spt_pkg::cell_wr_t        wr_i,
  input  logic [IDX_W-1:0]         wr_idx_i,
  input  spt_pkg::cell_flags_t     nbr_i,
  output spt_pkg::cell_flags_t     flags_o,
  output logic                     used_o
);

  logic [1:0]           kind_q, kind_d;
  logic [31:0]          ip_q, ip_d;
  logic [15:0]          port_q, port_d;
  spt_pkg::cell_flags_t flags_q, flags_d;
  spt_pkg::cell_flags_t cmp;
  logic                 port_eq, ip_ok, sel;

  // Compare this entry against the broadcast request
  always_comb begin
    port_eq     = (port_q == req_i.port);
    ip_ok       = (ip_q == 32'd0) || (req_i.ip == 32'd0) || (ip_q == req_i.ip);
    cmp.kind    = kind_q;
    cmp.port    = port_q;
    cmp.exact   = (kind_q == spt_pkg::KIND_UDP) && port_eq && (ip_q == req_i.ip);
    cmp.wild    = (kind_q == spt_pkg::KIND_UDP) && port_eq && (ip_q == 32'd0);
    cmp.conf_u  = (kind_q == spt_pkg::KIND_UDP) && port_eq && ip_ok;
    cmp.conf_t  = (kind_q == spt_pkg::KIND_TCP) && port_eq && ip_ok;
  end

  // Ephemeral candidate check
  assign used_o = (kind_q != spt_pkg::KIND_FREE) && (port_q == req_i.cand);

  // Flag stage: load own compare, or take the neighbor's
  always_comb begin
    flags_d = flags_q;
    if (req_i.load) begin
      flags_d = cmp;
    end else if (req_i.shift) begin
      flags_d = nbr_i;
    end
  end

  assign flags_o = flags_q;

  // Entry update
  assign sel = wr_i.en && (wr_idx_i == IDX_W'(CELL_ID));
  always_comb begin
    kind_d = kind_q;
    ip_d   = ip_q;
    port_d = port_q;
    if (sel && wr_i.wr_kind) begin
      kind_d = wr_i.kind;
    end
    if (sel && wr_i.wr_ip) begin
      ip_d = wr_i.ip;
    end
    if (sel && wr_i.wr_port) begin
      port_d = wr_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= spt_pkg::KIND_FREE;
    end else begin
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q    <= ip_d;
    port_q  <= port_d;
    flags_q <= flags_d;
  end

endmodule

@@ rtl/core/spt_ctrl.sv @@
`include "assert_macros.svh"

module spt_ctrl #(
  parameter int unsigned N     = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  spt_cmd_if.sink              cmd_i,
  spt_rsp_if.source            rsp_o,
  spt_cfg_if.sink              cfg_i,
  input  spt_pkg::cell_flags_t head_i,
  input  logic [N-1:0]         used_i,
  output spt_pkg::cell_req_t   req_o,
  output spt_pkg::cell_wr_t    wr_o,
  output logic [IDX_W-1:0]     wr_idx_o
);

  localparam int unsigned CW = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(N - 1);
  localparam logic [spt_pkg::TryW-1:0] LastTry = spt_pkg::TryW'(spt_pkg::EphTries - 1);

  spt_pkg::state_e      state_q, state_d;
  logic [2:0]           cmd_q, cmd_d;
  logic                 skind_q, skind_d;
  logic [3:0]           idx_q, idx_d;
  logic [31:0]          ip_q, ip_d;
  logic [15:0]          port_q, port_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 ffree_q, ffree_d, fexact_q, fexact_d, fwild_q, fwild_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d, ex_idx_q, ex_idx_d, wi_idx_q, wi_idx_d;
  logic                 cu_q, cu_d, ct_q, ct_d;
  logic [1:0]           tk_q, tk_d;
  logic [15:0]          tp_q, tp_d;
  logic [15:0]          nxt_q, nxt_d, base_q, base_d;
  logic [spt_pkg::TryW-1:0] try_q, try_d;
  logic                 ov_q, ov_d, st_q, st_d;
  logic [3:0]           ri_q, ri_d;
  logic [15:0]          rp_q, rp_d;
  logic                 in_fire, valid_tgt, conflict, taken;
  logic [15:0]          nxt_inc;
  logic [CW-1:0]        ext_idx;

  assign cmd_i.ready  = (state_q == spt_pkg::S_IDLE);
  assign in_fire      = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = ov_q;
  assign rsp_o.status = st_q;
  assign rsp_o.result_index = ri_q;
  assign rsp_o.result_port  = rp_q;

  // Broadcast to the cells
  always_comb begin
    req_o.load  = (state_q == spt_pkg::S_LOAD);
    req_o.shift = (state_q == spt_pkg::S_SCAN);
    req_o.ip    = ip_q;
    req_o.port  = port_q;
    req_o.cand  = nxt_q;
  end

  assign valid_tgt = (CW'(idx_q) < CW'(N)) && (tk_q != spt_pkg::KIND_FREE);
  assign conflict  = (tk_q == spt_pkg::KIND_UDP) ? cu_q : ct_q;
  assign taken     = (nxt_q >= base_q) && !(|used_i);
  assign nxt_inc   = nxt_q + 16'd1;

  // Command sequencer
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; skind_d = skind_q; idx_d = idx_q; ip_d = ip_q; port_d = port_q;
    cnt_d = cnt_q;
    ffree_d = ffree_q; fexact_d = fexact_q; fwild_d = fwild_q;
    free_idx_d = free_idx_q; ex_idx_d = ex_idx_q; wi_idx_d = wi_idx_q;
    cu_d = cu_q; ct_d = ct_q; tk_d = tk_q; tp_d = tp_q;
    nxt_d = nxt_q; try_d = try_q;
    base_d = cfg_i.valid ? cfg_i.ephemeral_base : base_q;
    ov_d = ov_q; st_d = st_q; ri_d = ri_q; rp_d = rp_q;
    wr_o = '0;
    wr_idx_o = IDX_W'(idx_q);
    ext_idx = '0;

    if (rsp_o.valid && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      spt_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_d   = cmd_i.cmd;
          skind_d = cmd_i.sock_kind;
          idx_d   = cmd_i.sock_index;
          ip_d    = cmd_i.ip_addr;
          port_d  = cmd_i.port_num;
          state_d = spt_pkg::S_LOAD;
        end
      end
      spt_pkg::S_LOAD: begin
        cnt_d = '0;
        ffree_d = 1'b0; fexact_d = 1'b0; fwild_d = 1'b0;
        cu_d = 1'b0; ct_d = 1'b0;
        tk_d = spt_pkg::KIND_FREE; tp_d = '0;
        state_d = spt_pkg::S_SCAN;
      end
      spt_pkg::S_SCAN: begin
        // Head of the chain shows entry cnt_q
        if ((head_i.kind == spt_pkg::KIND_FREE) && !ffree_q) begin
          ffree_d = 1'b1; free_idx_d = cnt_q;
        end
        if (head_i.exact && !fexact_q) begin
          fexact_d = 1'b1; ex_idx_d = cnt_q;
        end
        if (head_i.wild) begin
          fwild_d = 1'b1; wi_idx_d = cnt_q;
        end
        cu_d = cu_q | head_i.conf_u;
        ct_d = ct_q | head_i.conf_t;
        if (CW'(cnt_q) == CW'(idx_q)) begin
          tk_d = head_i.kind; tp_d = head_i.port;
        end
        if (cnt_q == LastIdx) begin
          state_d = spt_pkg::S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      spt_pkg::S_DONE: begin
        // Wait here while the previous result beat is still pending
        if (!ov_q || (rsp_o.valid && rsp_o.ready)) begin
          state_d = spt_pkg::S_IDLE;
          ov_d = 1'b1; st_d = 1'b1; ri_d = '0; rp_d = '0;
          case (cmd_q)
            spt_pkg::CMD_OPEN: begin
              if (ffree_q) begin
                wr_o.en = 1'b1; wr_o.wr_kind = 1'b1; wr_o.wr_ip = 1'b1; wr_o.wr_port = 1'b1;
                wr_o.kind = skind_q ? spt_pkg::KIND_TCP : spt_pkg::KIND_UDP;
                wr_idx_o = free_idx_q;
                ext_idx = CW'(free_idx_q);
                st_d = 1'b0; ri_d = ext_idx[3:0];
              end
            end
            spt_pkg::CMD_BIND: begin
              if (valid_tgt && (port_q != 16'd0) && !conflict) begin
                wr_o.en = 1'b1; wr_o.wr_ip = 1'b1; wr_o.wr_port = 1'b1;
                wr_o.ip = ip_q; wr_o.port = port_q;
                st_d = 1'b0;
              end
            end
            spt_pkg::CMD_CLOSE: begin
              if (valid_tgt) begin
                wr_o.en = 1'b1; wr_o.wr_kind = 1'b1; wr_o.wr_ip = 1'b1; wr_o.wr_port = 1'b1;
                wr_o.kind = spt_pkg::KIND_FREE;
                st_d = 1'b0;
              end
            end
            spt_pkg::CMD_LOOKUP: begin
              if (fexact_q) begin
                ext_idx = CW'(ex_idx_q);
                st_d = 1'b0; ri_d = ext_idx[3:0];
              end else if (fwild_q) begin
                ext_idx = CW'(wi_idx_q);
                st_d = 1'b0; ri_d = ext_idx[3:0];
              end
            end
            spt_pkg::CMD_AUTO: begin
              if (valid_tgt && (tk_q == spt_pkg::KIND_UDP)) begin
                if (tp_q != 16'd0) begin
                  st_d = 1'b0; rp_d = tp_q;
                end else begin
                  ov_d = 1'b0;
                  try_d = '0;
                  state_d = spt_pkg::S_TRY;
                end
              end
            end
            default: ;
          endcase
        end
      end
      spt_pkg::S_TRY: begin
        // One ephemeral candidate per cycle
        nxt_d = (nxt_inc == 16'd0) ? base_q : nxt_inc;
        try_d = try_q + 1'b1;
        if (taken) begin
          wr_o.en = 1'b1; wr_o.wr_port = 1'b1; wr_o.port = nxt_q;
          ov_d = 1'b1; st_d = 1'b0; ri_d = '0; rp_d = nxt_q;
          state_d = spt_pkg::S_IDLE;
        end else if (try_q == LastTry) begin
          ov_d = 1'b1; st_d = 1'b1; ri_d = '0; rp_d = '0;
          state_d = spt_pkg::S_IDLE;
        end
      end
      default: state_d = spt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spt_pkg::S_IDLE;
      ov_q    <= 1'b0;
      nxt_q   <= spt_pkg::EphReset;
      base_q  <= spt_pkg::EphReset;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      nxt_q   <= nxt_d;
      base_q  <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; skind_q <= skind_d; idx_q <= idx_d; ip_q <= ip_d; port_q <= port_d;
    cnt_q <= cnt_d;
    ffree_q <= ffree_d; fexact_q <= fexact_d; fwild_q <= fwild_d;
    free_idx_q <= free_idx_d; ex_idx_q <= ex_idx_d; wi_idx_q <= wi_idx_d;
    cu_q <= cu_d; ct_q <= ct_d; tk_q <= tk_d; tp_q <= tp_d;
    try_q <= try_d;
    st_q <= st_d; ri_q <= ri_d; rp_q <= rp_d;
  end

  `SPT_ASSERT(a_accept_loads, clk_i, rst_ni, in_fire |=> (state_q == spt_pkg::S_LOAD), "accepted beat did not start a compare")
  `SPT_ASSERT(a_scan_ends, clk_i, rst_ni, ((state_q == spt_pkg::S_SCAN) && (cnt_q == LastIdx)) |=> (state_q == spt_pkg::S_DONE), "scan overran the chain")
  `SPT_NEVER(a_write_phase, clk_i, rst_ni, wr_o.en && (state_q != spt_pkg::S_DONE) && (state_q != spt_pkg::S_TRY), "entry write outside result phase")
  `SPT_NEVER(a_try_result, clk_i, rst_ni, ov_q && (state_q == spt_pkg::S_TRY), "result pending during port search")

endmodule

@@ rtl/core/socket_port_table_unit.sv @@
// Socket port table: one command per beat, one result beat per command.
// Open, bind, close and lookup run through a load state, a flag shift down the cell
// chain (N = TABLE_ENTRIES entries) and a result state, which waits while an earlier
// result is pending; a new command is taken only once the previous one has finished.
// Auto-bind on an unbound UDP entry tries up to 16384 ephemeral candidates.
// Reset empties the table and sets the ephemeral base and next port to 49152.
module socket_port_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  spt_cmd_if.sink   cmd_i,
  spt_rsp_if.source rsp_o,
  spt_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  spt_pkg::cell_req_t   req;
  spt_pkg::cell_wr_t    wr;
  logic [IdxW-1:0]      wr_idx;
  spt_pkg::cell_flags_t flags [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used;

  // Row of entry cells, flags move toward cell 0
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    spt_pkg::cell_flags_t nbr;
    if (k == TABLE_ENTRIES - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = flags[k+1];
    end
    spt_cell #(
      .IDX_W   (IdxW),
      .CELL_ID (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req),
      .wr_i     (wr),
      .wr_idx_i (wr_idx),
      .nbr_i    (nbr),
      .flags_o  (flags[k]),
      .used_o   (used[k])
    );
  end

  spt_ctrl #(
    .N     (TABLE_ENTRIES),
    .IDX_W (IdxW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .rsp_o    (rsp_o),
    .cfg_i    (cfg_i),
    .head_i   (flags[0]),
    .used_i   (used),
    .req_o    (req),
    .wr_o     (wr),
    .wr_idx_o (wr_idx)
  );

endmodule
